FILE: hdl/ptw_pkg.sv
// shared types, constants and helpers of the page table map/unmap block
`default_nettype none

package ptw_pkg;

  localparam int unsigned POOL_PAGES_DEF = 64;
  localparam int unsigned ENT_IDX_W      = 9;
  localparam int unsigned ENT_PER_PAGE   = 512;
  localparam int unsigned ENT_W          = 64;
  localparam int unsigned FRAME_W        = 40;
  localparam int unsigned VA_W           = 57;
  localparam int unsigned CFG_IDX_W      = 4;
  localparam int unsigned CFG_DATA_W     = 40;

  // table levels, counted up from the page table
  typedef logic [2:0] lvl_t;
  localparam lvl_t LVL_PT   = 3'd0;
  localparam lvl_t LVL_PD   = 3'd1;
  localparam lvl_t LVL_PDPT = 3'd2;
  localparam lvl_t LVL_PML4 = 3'd3;
  localparam lvl_t LVL_PML5 = 3'd4;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd2;
  localparam logic [1:0] ST_OUTSIDE    = 2'd3;

  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_UNMAP = 1'b1;

  localparam logic [1:0] CM_WC = 2'd1;
  localparam logic [1:0] CM_UC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIVE_LEVEL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 4'd1;

  // low attribute bits of a freshly linked table entry: present, writable, user
  localparam logic [11:0] LINK_ATTR = 12'h007;

  typedef struct packed {
    logic               operation;
    logic [VA_W-1:0]    virt_addr;
    logic [FRAME_W-1:0] phys_frame;
    logic               writable;
    logic               executable;
    logic               user_access;
    logic               global_page;
    logic               huge_page;
    logic [1:0]         cache_mode;
  } ptw_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ENT_W-1:0] entry_value;
  } ptw_out_t;

  typedef struct packed {
    logic       load_item;
    logic       mem_rd;
    logic       descend;
    logic       alloc_clr;
    logic       link;
    logic       leaf_wr;
    logic       init_clr;
    logic       finish;
    logic [1:0] status;
    logic       out_load;
  } ptw_cmd_t;

  typedef struct packed {
    logic init_last;
    logic alloc_last;
    logic is_unmap;
    logic present;
    logic huge;
    logic ptr_ok;
    logic pool_full;
    logic next_is_leaf;
    logic lvl_is_pt;
    logic lvl_is_pd;
    logic out_free;
  } ptw_sts_t;

  function automatic logic [ENT_IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                    input lvl_t lvl);
    logic [ENT_IDX_W-1:0] idx;
    case (lvl)
      LVL_PT:   idx = va[20:12];
      LVL_PD:   idx = va[29:21];
      LVL_PDPT: idx = va[38:30];
      LVL_PML4: idx = va[47:39];
      LVL_PML5: idx = va[56:48];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [ENT_W-1:0] make_leaf(input ptw_in_t it);
    logic [ENT_W-1:0] pte;
    pte        = '0;
    pte[0]     = 1'b1;
    pte[1]     = it.writable;
    pte[2]     = it.user_access;
    pte[3]     = (it.cache_mode == CM_WC) || (it.cache_mode == CM_UC);
    pte[4]     = (it.cache_mode == CM_UC);
    pte[7]     = it.huge_page;
    pte[8]     = it.global_page;
    pte[51:12] = it.phys_frame;
    pte[63]    = ~it.executable;
    return pte;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/x86_page_table_map_unmap.sv
// Keeps x86-64 four- or five-level page tables in a pool of POOL_PAGES table
// pages (pool page 0 is the root) and serves one map or unmap transaction at a
// time, each giving one result. After reset the block clears the whole pool
// and takes no transaction until that ends (config writes are taken
// throughout). A request walks the tables through the single-read pool memory,
// with a read and an evaluate step for each table entry that it reads, then
// the entry write and the output load; a map does not read the leaf entry it
// writes, while an unmap reads the leaf entry as well, and a request that
// stops early on an error skips the entry write. Every new table has its 512
// entries zeroed one a cycle and is then linked. The next request is accepted
// while the previous result still waits in the output register.
`default_nettype none

module x86_page_table_map_unmap
  import ptw_pkg::*;
#(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire ptw_in_t               in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      ptw_out_t              out_data_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ptw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptw_dp #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef SYNTHESIS
  // an accepted transaction keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a transaction");

  // only one pool write source at a time
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.init_clr, cmd.alloc_clr, cmd.link, cmd.leaf_wr}))
    else $error("more than one pool write in a cycle");

  a_leaf_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.leaf_wr |-> (cmd.finish && (cmd.status == ST_DONE)))
    else $error("leaf write without a done result");

  // never overwrite a result that is still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result register loaded while occupied");
`endif

endmodule

`default_nettype wire

FILE: hdl/ptw_mem.sv
// table pool storage: one write port, one registered read port
`default_nettype none

module ptw_mem
  import ptw_pkg::*;
#(
  parameter int unsigned DEPTH  = POOL_PAGES_DEF * ENT_PER_PAGE,
  parameter int unsigned ADDR_W = $clog2(POOL_PAGES_DEF * ENT_PER_PAGE)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [ENT_W-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [ENT_W-1:0]  rdata_o
);

  logic [ENT_W-1:0] mem_q [DEPTH];
  logic [ENT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/ptw_ctrl.sv
// walk controller: sequences reset clear, table reads, allocation and leaf write
`default_nettype none

module ptw_ctrl
  import ptw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_stall_o,
  input  wire ptw_sts_t sts_i,
  output      ptw_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_ALLOC = 9'b000010000,
    S_LINK  = 9'b000100000,
    S_LEAF  = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.init_clr = 1'b1;
        if (sts_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_RD;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        if (!sts_i.is_unmap) begin
          if (!sts_i.present) begin
            if (sts_i.pool_full) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_EXHAUSTED;
              state_d      = S_OUT;
            end else begin
              state_d = S_ALLOC;
            end
          end else if (!sts_i.ptr_ok) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_OUTSIDE;
            state_d      = S_OUT;
          end else begin
            cmd_o.descend = 1'b1;
            state_d       = sts_i.next_is_leaf ? S_LEAF : S_RD;
          end
        end else if (sts_i.lvl_is_pt || (sts_i.lvl_is_pd && sts_i.huge)) begin
          // last entry of the unmap walk: clear present or report nothing mapped
          if (!sts_i.present) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_NOT_MAPPED;
            state_d      = S_OUT;
          end else begin
            state_d = S_LEAF;
          end
        end else if (!sts_i.present) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_NOT_MAPPED;
          state_d      = S_OUT;
        end else if (!sts_i.ptr_ok) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_OUTSIDE;
          state_d      = S_OUT;
        end else begin
          cmd_o.descend = 1'b1;
          state_d       = S_RD;
        end
      end
      S_ALLOC: begin
        cmd_o.alloc_clr = 1'b1;
        if (sts_i.alloc_last) state_d = S_LINK;
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = sts_i.next_is_leaf ? S_LEAF : S_RD;
      end
      S_LEAF: begin
        cmd_o.leaf_wr = 1'b1;
        cmd_o.finish  = 1'b1;
        cmd_o.status  = ST_DONE;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: hdl/ptw_dp.sv
// walk datapath: config registers, request registers, address and entry logic
`default_nettype none

module ptw_dp
  import ptw_pkg::*;
#(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire ptw_in_t               in_data_i,
  input  wire logic                  out_stall_i,
  output      logic                  out_valid_o,
  output      ptw_out_t              out_data_o,
  input  wire ptw_cmd_t              cmd_i,
  output      ptw_sts_t              sts_o
);

  localparam int unsigned PW     = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned NFP_W  = $clog2(POOL_PAGES + 1);
  localparam int unsigned DEPTH  = POOL_PAGES * ENT_PER_PAGE;
  localparam int unsigned ADDR_W = PW + ENT_IDX_W;

  logic                five_level_q;
  logic [FRAME_W-1:0]  pool_base_q;
  ptw_in_t             item_q;
  lvl_t                lvl_q;
  logic [PW-1:0]       page_q;
  logic [NFP_W-1:0]    nfp_q;
  logic [ADDR_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [1:0]          res_status_q;
  logic [ENT_W-1:0]    res_val_q;
  logic                out_valid_q;
  ptw_out_t            out_data_q;

  logic [ENT_W-1:0]    rd_data;
  logic [FRAME_W-1:0]  rel;
  logic [FRAME_W-1:0]  link_frame;
  logic [ENT_W-1:0]    link_ent;
  logic [ENT_W-1:0]    leaf_data;
  logic [ADDR_W-1:0]   slot_addr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ENT_W-1:0]    mem_wdata;
  lvl_t                leaf_lvl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      five_level_q <= 1'b0;
      pool_base_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIVE_LEVEL: five_level_q <= cfg_data_i[0];
        CFG_POOL_BASE:  pool_base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pointer decode and new table pointer
  assign rel        = rd_data[51:12] - pool_base_q;
  assign link_frame = pool_base_q + FRAME_W'(nfp_q);
  assign link_ent   = {12'h000, link_frame, LINK_ATTR};
  assign leaf_lvl   = item_q.huge_page ? LVL_PD : LVL_PT;
  assign leaf_data  = (item_q.operation == OP_UNMAP) ? (rd_data & ~ENT_W'(1))
                                                     : make_leaf(item_q);
  assign slot_addr  = {page_q, va_index(item_q.virt_addr, lvl_q)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
      lvl_q  <= five_level_q ? LVL_PML5 : LVL_PML4;
      page_q <= '0;
    end else if (cmd_i.descend) begin
      lvl_q  <= lvl_q - 3'd1;
      page_q <= rel[PW-1:0];
    end else if (cmd_i.link) begin
      lvl_q  <= lvl_q - 3'd1;
      page_q <= nfp_q[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nfp_q <= NFP_W'(1);
    end else if (cmd_i.link) begin
      nfp_q <= nfp_q + NFP_W'(1);
    end
  end

  // sweep counter shared by the reset clear and the new-table clear
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if ((cmd_i.init_clr && sts_o.init_last) || (cmd_i.alloc_clr && sts_o.alloc_last)) begin
      clr_cnt_d = '0;
    end else if (cmd_i.init_clr || cmd_i.alloc_clr) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_addr;
    mem_wdata = '0;
    if (cmd_i.init_clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
    end else if (cmd_i.alloc_clr) begin
      mem_we    = 1'b1;
      mem_waddr = {nfp_q[PW-1:0], clr_cnt_q[ENT_IDX_W-1:0]};
    end else if (cmd_i.link) begin
      mem_we    = 1'b1;
      mem_wdata = link_ent;
    end else if (cmd_i.leaf_wr) begin
      mem_we    = 1'b1;
      mem_wdata = leaf_data;
    end
  end

  ptw_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (slot_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.status;
      res_val_q    <= (cmd_i.status == ST_DONE) ? leaf_data : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.status      <= res_status_q;
      out_data_q.entry_value <= res_val_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.init_last    = (clr_cnt_q == ADDR_W'(DEPTH - 1));
  assign sts_o.alloc_last   = &clr_cnt_q[ENT_IDX_W-1:0];
  assign sts_o.is_unmap     = (item_q.operation == OP_UNMAP);
  assign sts_o.present      = rd_data[0];
  assign sts_o.huge         = rd_data[7];
  assign sts_o.ptr_ok       = (rel < FRAME_W'(POOL_PAGES));
  assign sts_o.pool_full    = (nfp_q == NFP_W'(POOL_PAGES));
  assign sts_o.next_is_leaf = (lvl_q == (leaf_lvl + 3'd1));
  assign sts_o.lvl_is_pt    = (lvl_q == LVL_PT);
  assign sts_o.lvl_is_pd    = (lvl_q == LVL_PD);
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

FILE: verif/x86_page_table_map_unmap_tb.sv
// testbench of the page table map/unmap block: shadow page tables predict every result
module x86_page_table_map_unmap_tb;
  import ptw_pkg::*;

  localparam int unsigned POOL           = POOL_PAGES_DEF;
  localparam int          CLK_PERIOD     = 20;
  localparam int unsigned WATCHDOG_LIMIT = 100000;
  localparam int unsigned MAX_GAP        = 14;
  localparam int unsigned PREFIXES       = 4;
  localparam int unsigned PHASE_ITEMS    = 230;
  localparam int unsigned P_BIT          = 0;
  localparam int unsigned PS_BIT         = 7;

  localparam logic [1:0] CM_WB   = 2'd0;
  localparam logic [1:0] CM_RSVD = 2'd3;

  // flag order: writable, executable, user, global, huge
  localparam logic [4:0] F_NONE  = 5'b00000;
  localparam logic [4:0] F_RWX   = 5'b11100;
  localparam logic [4:0] F_ALL4K = 5'b11110;
  localparam logic [4:0] F_HUGE  = 5'b00001;
  localparam logic [4:0] F_ALL   = 5'b11111;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  ptw_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ptw_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow copy of the table pool and walker registers
  logic [ENT_W-1:0]   shadow_pt [POOL*ENT_PER_PAGE];
  int unsigned        next_table;
  logic               five_lvl;
  logic [FRAME_W-1:0] base_frame;

  ptw_out_t    pending_results[$];
  int unsigned err_cnt      = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;
  int unsigned rx_wait      = 0;
  int unsigned rx_hold      = 0;
  logic [8:0]  pfx_idx [PREFIXES][4];

  x86_page_table_map_unmap #(.POOL_PAGES(POOL)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned draw_gap(input bit on);
    return on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic logic [VA_W-1:0] make_va(input logic [8:0] i4, i3, i2, i1, i0,
                                              input logic [11:0] off);
    return {i4, i3, i2, i1, i0, off};
  endfunction

  function automatic ptw_in_t make_req(input logic op, input logic [VA_W-1:0] va,
                                       input logic [FRAME_W-1:0] frame,
                                       input logic [4:0] flags, input logic [1:0] cm);
    return {op, va, frame, flags, cm};
  endfunction

  function automatic int unsigned entry_slot(input int unsigned page,
                                             input logic [VA_W-1:0] va, input int lvl);
    logic [VA_W-1:0] sh;
    sh = va >> (12 + 9 * lvl);
    return page * ENT_PER_PAGE + sh[8:0];
  endfunction

  // pool page an entry points to, false when it lies outside the pool
  function automatic bit table_of(input logic [ENT_W-1:0] ent, output int unsigned page);
    logic [FRAME_W-1:0] rel;
    rel  = ent[51:12] - base_frame;
    page = rel[31:0];
    return rel < POOL;
  endfunction

  function automatic logic [ENT_W-1:0] leaf_entry(input ptw_in_t rq);
    logic pwt, pcd;
    pcd = (rq.cache_mode == CM_UC);
    pwt = (rq.cache_mode == CM_WC) || pcd;
    return {~rq.executable, 11'b0, rq.phys_frame, 3'b0, rq.global_page, rq.huge_page,
            2'b0, pcd, pwt, rq.user_access, rq.writable, 1'b1};
  endfunction

  function automatic logic [1:0] map_page(input ptw_in_t rq, output logic [ENT_W-1:0] val);
    int lvl, stop;
    int unsigned page, a, np, i;
    logic [ENT_W-1:0] ent;
    val  = '0;
    page = 0;
    stop = rq.huge_page ? 1 : 0;
    for (lvl = five_lvl ? 4 : 3; lvl > stop; lvl--) begin
      a   = entry_slot(page, rq.virt_addr, lvl);
      ent = shadow_pt[a];
      if (!ent[P_BIT]) begin
        if (next_table >= POOL) return ST_EXHAUSTED;
        np         = next_table;
        next_table = next_table + 1;
        for (i = 0; i < ENT_PER_PAGE; i++) shadow_pt[np*ENT_PER_PAGE + i] = '0;
        ent        = '0;
        ent[51:12] = base_frame + np;
        ent[11:0]  = LINK_ATTR;
        shadow_pt[a] = ent;
      end
      if (!table_of(ent, page)) return ST_OUTSIDE;
    end
    val = leaf_entry(rq);
    shadow_pt[entry_slot(page, rq.virt_addr, stop)] = val;
    return ST_DONE;
  endfunction

  function automatic logic [1:0] unmap_page(input ptw_in_t rq, output logic [ENT_W-1:0] val);
    int lvl;
    int unsigned page, a;
    logic [ENT_W-1:0] ent;
    val  = '0;
    page = 0;
    for (lvl = five_lvl ? 4 : 3; lvl > 1; lvl--) begin
      ent = shadow_pt[entry_slot(page, rq.virt_addr, lvl)];
      if (!ent[P_BIT]) return ST_NOT_MAPPED;
      if (!table_of(ent, page)) return ST_OUTSIDE;
    end
    a   = entry_slot(page, rq.virt_addr, 1);
    ent = shadow_pt[a];
    // a directory entry with PS is the leaf itself
    if (!ent[PS_BIT]) begin
      if (!ent[P_BIT]) return ST_NOT_MAPPED;
      if (!table_of(ent, page)) return ST_OUTSIDE;
      a   = entry_slot(page, rq.virt_addr, 0);
      ent = shadow_pt[a];
    end
    if (!ent[P_BIT]) return ST_NOT_MAPPED;
    ent[P_BIT]   = 1'b0;
    shadow_pt[a] = ent;
    val          = ent;
    return ST_DONE;
  endfunction

  function automatic ptw_out_t walk_tables(input ptw_in_t rq);
    ptw_out_t res;
    if (rq.operation == OP_MAP) res.status = map_page(rq, res.entry_value);
    else res.status = unmap_page(rq, res.entry_value);
    if (res.status != ST_DONE) res.entry_value = '0;
    return res;
  endfunction

  task automatic issue_request(input ptw_in_t rq);
    int unsigned gap;
    gap = draw_gap(tx_idle_on);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk_i); while (in_stall);
    pending_results.push_back(walk_tables(rq));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_walker(input logic five, input logic [FRAME_W-1:0] base);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FIVE_LEVEL;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, five};
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_POOL_BASE;
    cfg_data  <= base;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    five_lvl   = five;
    base_frame = base;
  endtask

  task automatic check_result(input ptw_out_t got);
    ptw_out_t exp;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d entry_value %h", got.status, got.entry_value);
      err_cnt++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      err_cnt++;
    end
    if (got.entry_value !== exp.entry_value) begin
      $error("entry_value: expected %h, got %h", exp.entry_value, got.entry_value);
      err_cnt++;
    end
  endtask

  // receiver: per-transaction stall plus an optional long hold
  always @(posedge clk_i) begin
    if (out_valid === 1'b1 && !out_stall) begin
      check_result(out_data);
      rx_wait = draw_gap(rx_idle_on);
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    if (rx_hold != 0) rx_hold--;
    out_stall <= (rx_wait != 0) || (rx_hold != 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed_map_unmap();
    logic [63:0] r;
    program_walker(1'b0, '0);
    r = rand64();
    issue_request(make_req(OP_UNMAP, '0, '0, F_NONE, CM_WB));   // empty root
    issue_request(make_req(OP_MAP, '0, '0, F_NONE, CM_WB));
    issue_request(make_req(OP_MAP, '0, '1, F_ALL4K, CM_WC));    // overwrite
    issue_request(make_req(OP_MAP, make_va(0, 0, 0, 0, 1, 0), r[39:0], F_RWX, CM_UC));
    issue_request(make_req(OP_MAP, make_va(0, 0, 0, 0, 2, 12'hfff), r[63:24], F_RWX, CM_RSVD));
    issue_request(make_req(OP_UNMAP, '0, '0, F_NONE, CM_WB));
    issue_request(make_req(OP_UNMAP, '0, '0, F_NONE, CM_WB));   // leaf already cleared
    issue_request(make_req(OP_UNMAP, make_va(0, 0, 0, 0, 5, 0), '0, F_NONE, CM_WB));
    // 2 MiB pages
    issue_request(make_req(OP_MAP, make_va(0, 0, 0, 1, 0, 0), r[47:8], F_ALL, CM_WC));
    issue_request(make_req(OP_UNMAP, make_va(0, 0, 0, 1, 0, 0), '0, F_HUGE, CM_WB));
    issue_request(make_req(OP_UNMAP, make_va(0, 0, 0, 1, 0, 0), '0, F_HUGE, CM_WB));
    // a 4K walk through a huge entry decodes its frame as a table
    issue_request(make_req(OP_MAP, make_va(0, 0, 0, 2, 0, 0), 40'hab_cdef_0123, F_HUGE, CM_WB));
    issue_request(make_req(OP_MAP, make_va(0, 0, 0, 2, 7, 0), r[39:0], F_RWX, CM_WB));
    issue_request(make_req(OP_UNMAP, make_va(0, 0, 0, 2, 7, 0), '0, F_NONE, CM_WB));
    issue_request(make_req(OP_MAP, '1, '1, F_ALL4K, CM_UC));
    // four-level walks ignore bits 56..48
    issue_request(make_req(OP_UNMAP, {9'h000, 48'hffff_ffff_ffff}, '0, F_NONE, CM_WB));
    issue_request(make_req(OP_UNMAP, make_va(0, 5, 0, 0, 0, 0), '0, F_NONE, CM_WB));
  endtask

  task automatic test_five_level();
    program_walker(1'b1, '0);
    issue_request(make_req(OP_MAP, '1, 40'h00_0000_0001, F_RWX, CM_WB));
    issue_request(make_req(OP_MAP, make_va(9'h155, 9'h0aa, 3, 4, 5, 0), '1, F_ALL, CM_UC));
    issue_request(make_req(OP_UNMAP, make_va(9'h155, 9'h0aa, 3, 4, 5, 0), '0, F_HUGE, CM_WB));
    issue_request(make_req(OP_UNMAP, make_va(9'h001, 0, 0, 0, 0, 0), '0, F_NONE, CM_WB));
  endtask

  task automatic test_outside_pointer();
    program_walker(1'b0, 40'h5a_5a5a_5a5a);
    issue_request(make_req(OP_UNMAP, '0, '0, F_NONE, CM_WB));
    issue_request(make_req(OP_MAP, '0, '0, F_RWX, CM_WB));
    issue_request(make_req(OP_MAP, make_va(0, 300, 1, 1, 1, 0), 40'h12_3456_789a, F_RWX, CM_WC));
  endtask

  function automatic ptw_in_t random_request();
    ptw_in_t     rq;
    int unsigned k;
    logic [63:0] r;
    logic [8:0]  pd, pt;
    k              = $urandom_range(0, PREFIXES-1);
    rq.operation   = ($urandom_range(0, 99) < 55) ? OP_MAP : OP_UNMAP;
    rq.huge_page   = ($urandom_range(0, 99) < 15);
    rq.writable    = $urandom_range(0, 1);
    rq.executable  = $urandom_range(0, 1);
    rq.user_access = $urandom_range(0, 1);
    rq.global_page = $urandom_range(0, 1);
    rq.cache_mode  = $urandom_range(0, 3);
    r = rand64();
    // some frames land inside the pool so huge leaves can act as table pointers
    if ($urandom_range(0, 9) == 0) rq.phys_frame = base_frame + $urandom_range(0, POOL-1);
    else rq.phys_frame = r[FRAME_W-1:0];
    // huge pages mostly get a directory slot of their own
    pd = pfx_idx[k][3] + $urandom_range(0, 2);
    if (rq.huge_page && $urandom_range(0, 9) != 0) pd = pfx_idx[k][3] + 3;
    pt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 7);
    r = rand64();
    if ($urandom_range(0, 99) == 0) rq.virt_addr = r[VA_W-1:0];
    else rq.virt_addr = make_va(pfx_idx[k][0], pfx_idx[k][1], pfx_idx[k][2], pd, pt, r[11:0]);
    return rq;
  endfunction

  task automatic test_random_traffic();
    logic               ph_five [5];
    logic [FRAME_W-1:0] ph_base [5];
    int unsigned        ph, n;
    ph_five = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    ph_base = '{'0, '0, '1, '1, '0};
    foreach (pfx_idx[k, j]) pfx_idx[k][j] = $urandom_range(0, 511);
    for (ph = 0; ph < 5; ph++) begin
      program_walker(ph_five[ph], ph_base[ph]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          tx_idle_on = ($urandom_range(0, 3) != 0);
          rx_idle_on = ($urandom_range(0, 3) != 0);
        end
        // long receiver hold so the block backs up into its input
        if (ph == 1 && n == 80) rx_hold = 400;
        issue_request(random_request());
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_pool_exhaustion();
    int unsigned n;
    logic [63:0] r;
    program_walker(1'b0, '0);
    for (n = 0; n < 100 && next_table < POOL; n++) begin
      r = rand64();
      issue_request(make_req(OP_MAP, r[VA_W-1:0], r[63:24], F_RWX, CM_WB));
    end
    for (n = 0; n < 6; n++) begin
      r = rand64();
      issue_request(make_req((n % 2) ? OP_UNMAP : OP_MAP, r[VA_W-1:0], r[63:24], F_ALL4K, CM_UC));
    end
  endtask

  initial begin
    foreach (shadow_pt[i]) shadow_pt[i] = '0;
    next_table = 1;
    five_lvl   = 1'b0;
    base_frame = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_map_unmap();
    test_five_level();
    test_outside_pointer();
    test_random_traffic();
    test_pool_exhaustion();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: x86_page_table_map_unmap.f
hdl/ptw_pkg.sv
hdl/ptw_mem.sv
hdl/ptw_ctrl.sv
hdl/ptw_dp.sv
hdl/x86_page_table_map_unmap.sv
verif/x86_page_table_map_unmap_tb.sv
